// ===== hdl/eight_bit_cpu_subset_step_defines.svh =====
// Assertion macros for the processor subset step block.
// Included by the top level; no other dependencies.
`ifndef EIGHT_BIT_CPU_SUBSET_STEP_DEFINES_SVH
`define EIGHT_BIT_CPU_SUBSET_STEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/ebc_pkg.sv =====
// Shared types and constants for the processor subset step block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ebc_pkg;
    typedef enum logic [2:0] {
        CMD_STEP = 3'd0, CMD_RESET = 3'd1, CMD_NMI = 3'd2,
        CMD_WRITE = 3'd3, CMD_READ = 3'd4
    } t_cmd;
    localparam logic [7:0] OP_NOP = 8'hEA, OP_JMP = 8'h4C, OP_LDA_I = 8'hA9,
        OP_LDA_A = 8'hAD, OP_LDX = 8'hA2, OP_LDY = 8'hA0, OP_STA = 8'h8D,
        OP_ADC = 8'h69, OP_PHA = 8'h48, OP_PLA = 8'h68, OP_INX = 8'hE8,
        OP_BNE = 8'hD0, OP_BRK = 8'h00, OP_RTI = 8'h40;
    localparam logic [15:0] VEC_RESET = 16'hFFFC;
    localparam logic [15:0] VEC_NMI = 16'hFFFA;
    localparam logic [15:0] VEC_BRK = 16'hFFCD;
    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [7:0] SP_INIT = 8'hFD;
    localparam logic [7:0] STATUS_INIT = 8'h24;
    localparam int FLAG_C = 0, FLAG_Z = 1, FLAG_I = 2, FLAG_B = 4, FLAG_U = 5,
        FLAG_V = 6, FLAG_N = 7;
endpackage
`default_nettype wire

// ===== hdl/ebc_if.sv =====
// Valid/ready channel interfaces for commands and results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ebc_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    modport source (output valid, cmd, mem_addr, mem_data, input ready);
    modport sink (input valid, cmd, mem_addr, mem_data, output ready);
endinterface

interface ebc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] prog_counter;
    logic [7:0]  accum;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  flags;
    logic [7:0]  stack_ptr;
    logic [31:0] cycle_total;
    logic [7:0]  read_data;
    modport source (output valid, prog_counter, accum, index_x, index_y, flags,
        stack_ptr, cycle_total, read_data, input ready);
    modport sink (input valid, prog_counter, accum, index_x, index_y, flags,
        stack_ptr, cycle_total, read_data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ebc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ebc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    // write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/eight_bit_cpu_subset_step.sv =====
// Processor subset step: one command item in, one result item out.
// Each memory access goes through one single-port RAM (address, then data).
// Throughput: one item at a time; the next item is taken the cycle after the
// result item is accepted. Synchronous active-low reset sets the state and
// processor registers to their initial values, memory is not cleared.
// Depends on ebc_pkg, ebc_if, ebc_ram and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "eight_bit_cpu_subset_step_defines.svh"
module eight_bit_cpu_subset_step #(
    parameter int ADDR_BITS = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ebc_cmd_if.sink  i_cmd,
    ebc_res_if.source o_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FETCH, S_DECODE, S_OPER1, S_OPER2, S_MEMRD,
        S_WAIT, S_DONE
    } t_state;
    // what each access's data feeds
    typedef enum logic [3:0] {
        D_NONE, D_OPC, D_LO, D_HI, D_VLO, D_VHI, D_ACC, D_RD, D_STAT, D_PCLO, D_PCHI
    } t_dst;

    t_state r_state;
    t_dst   r_dst;
    logic [2:0]  r_cmd;
    logic [7:0]  r_opc, r_lo, r_a, r_x, r_y, r_p, r_sp, r_rd;
    logic [15:0] r_pc, r_addr;
    logic [31:0] r_cyc;
    logic [2:0]  r_step;
    logic        r_we;
    logic [7:0]  r_wdata, w_rdata;
    logic        r_valid;

    ebc_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_ram (
        .i_clk(i_clk), .i_we(r_we), .i_addr(r_addr[ADDR_BITS-1:0]),
        .i_wdata(r_wdata), .o_rdata(w_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE) && !r_valid;
    assign o_res.valid = r_valid;
    assign o_res.prog_counter = r_pc;
    assign o_res.accum = r_a;
    assign o_res.index_x = r_x;
    assign o_res.index_y = r_y;
    assign o_res.flags = r_p;
    assign o_res.stack_ptr = r_sp;
    assign o_res.cycle_total = r_cyc;
    assign o_res.read_data = r_rd;

    // adder for carry add (ADC only)
    logic [8:0] w_sum;
    logic [7:0] w_res;
    assign w_sum = {1'b0, r_a} + {1'b0, w_rdata} + {8'd0, r_p[ebc_pkg::FLAG_C]};
    assign w_res = w_sum[7:0];
    logic [15:0] w_word, w_bto;
    assign w_word = {w_rdata, r_lo};
    assign w_bto = r_pc + {{8{w_rdata[7]}}, w_rdata};

    function automatic logic [7:0] zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[ebc_pkg::FLAG_Z] = (v == 8'd0);
        q[ebc_pkg::FLAG_N] = v[7];
        return q;
    endfunction

    // sequencer: drives one RAM access at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_we <= 1'b0;
            r_a <= '0; r_x <= '0; r_y <= '0;
            r_p <= ebc_pkg::STATUS_INIT; r_sp <= ebc_pkg::SP_INIT;
            r_pc <= '0; r_cyc <= '0; r_rd <= '0;
            r_dst <= D_NONE; r_step <= '0;
        end else begin
            r_we <= 1'b0;
            if (r_valid && o_res.ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_cmd <= i_cmd.cmd;
                        r_addr <= i_cmd.mem_addr;
                        r_wdata <= i_cmd.mem_data;
                        r_rd <= '0;
                        r_step <= '0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_state <= S_WAIT;
                    unique case (r_cmd)
                        ebc_pkg::CMD_STEP: begin
                            r_addr <= r_pc; r_pc <= r_pc + 16'd1; r_dst <= D_OPC;
                        end
                        ebc_pkg::CMD_RESET: begin
                            r_a <= '0; r_x <= '0; r_y <= '0; r_cyc <= '0;
                            r_sp <= ebc_pkg::SP_INIT; r_p <= ebc_pkg::STATUS_INIT;
                            r_addr <= ebc_pkg::VEC_RESET; r_dst <= D_VLO;
                        end
                        ebc_pkg::CMD_NMI: begin
                            // push three bytes, then the vector
                            r_step <= r_step + 3'd1;
                            r_addr <= {ebc_pkg::STACK_PAGE, r_sp};
                            r_sp <= r_sp - 8'd1;
                            r_we <= 1'b1;
                            r_dst <= D_NONE;
                            r_state <= S_DISPATCH;
                            unique case (r_step)
                                3'd0: r_wdata <= r_pc[15:8];
                                3'd1: r_wdata <= r_pc[7:0];
                                3'd2: begin
                                    r_wdata <= (r_p & ~(8'd1 << ebc_pkg::FLAG_B))
                                        | (8'd1 << ebc_pkg::FLAG_U);
                                end
                                default: begin
                                    r_we <= 1'b0; r_sp <= r_sp;
                                    r_p[ebc_pkg::FLAG_I] <= 1'b1;
                                    r_cyc <= r_cyc + 32'd7;
                                    r_addr <= ebc_pkg::VEC_NMI; r_dst <= D_VLO;
                                    r_state <= S_WAIT;
                                end
                            endcase
                        end
                        ebc_pkg::CMD_WRITE: begin
                            r_we <= 1'b1; r_dst <= D_NONE;
                        end
                        ebc_pkg::CMD_READ: r_dst <= D_RD;
                        default: r_dst <= D_NONE;
                    endcase
                end
                S_WAIT: r_state <= S_MEMRD;
                S_MEMRD: begin
                    r_state <= S_DONE;
                    unique case (r_dst)
                        D_NONE: ;
                        D_RD: r_rd <= w_rdata;
                        D_OPC: begin
                            r_opc <= w_rdata;
                            r_state <= S_DECODE;
                        end
                        D_VLO, D_LO: begin
                            r_lo <= w_rdata; r_addr <= r_addr + 16'd1;
                            r_dst <= (r_dst == D_VLO) ? D_VHI : D_HI;
                            if (r_dst == D_LO) r_pc <= r_pc + 16'd1;
                            r_state <= S_WAIT;
                        end
                        D_VHI: r_pc <= w_word;
                        D_HI: begin
                            r_pc <= r_pc + 16'd1;
                            if (r_opc == ebc_pkg::OP_JMP) begin
                                r_pc <= w_word;
                            end else if (r_opc == ebc_pkg::OP_STA) begin
                                r_addr <= w_word; r_wdata <= r_a; r_we <= 1'b1;
                            end else begin
                                r_addr <= w_word; r_dst <= D_ACC; r_state <= S_WAIT;
                            end
                        end
                        D_ACC: begin
                            r_a <= w_rdata; r_p <= zn(r_p, w_rdata);
                        end
                        D_STAT: begin
                            r_p <= w_rdata; r_sp <= r_sp + 8'd1;
                            r_addr <= {ebc_pkg::STACK_PAGE, r_sp + 8'd1};
                            r_dst <= D_PCLO; r_state <= S_WAIT;
                        end
                        D_PCLO: begin
                            r_lo <= w_rdata; r_sp <= r_sp + 8'd1;
                            r_addr <= {ebc_pkg::STACK_PAGE, r_sp + 8'd1};
                            r_dst <= D_PCHI; r_state <= S_WAIT;
                        end
                        D_PCHI: r_pc <= w_word;
                        default: ;
                    endcase
                end
                S_DECODE: begin
                    // opcode known; immediate operands arrive on next access
                    r_state <= S_OPER1;
                    r_addr <= r_pc;
                    unique case (r_opc)
                        ebc_pkg::OP_JMP: r_cyc <= r_cyc + 32'd3;
                        ebc_pkg::OP_LDA_A, ebc_pkg::OP_STA: r_cyc <= r_cyc + 32'd4;
                        ebc_pkg::OP_LDA_I, ebc_pkg::OP_LDX, ebc_pkg::OP_LDY,
                        ebc_pkg::OP_ADC, ebc_pkg::OP_BNE: r_cyc <= r_cyc + 32'd2;
                        ebc_pkg::OP_PHA: begin
                            r_cyc <= r_cyc + 32'd3;
                            r_addr <= {ebc_pkg::STACK_PAGE, r_sp};
                            r_wdata <= r_a; r_we <= 1'b1;
                            r_sp <= r_sp - 8'd1;
                            r_state <= S_DONE;
                        end
                        ebc_pkg::OP_PLA: begin
                            r_cyc <= r_cyc + 32'd4;
                            r_sp <= r_sp + 8'd1;
                            r_addr <= {ebc_pkg::STACK_PAGE, r_sp + 8'd1};
                            r_dst <= D_ACC; r_state <= S_WAIT;
                        end
                        ebc_pkg::OP_RTI: begin
                            r_cyc <= r_cyc + 32'd6;
                            r_sp <= r_sp + 8'd1;
                            r_addr <= {ebc_pkg::STACK_PAGE, r_sp + 8'd1};
                            r_dst <= D_STAT; r_state <= S_WAIT;
                        end
                        ebc_pkg::OP_BRK: begin
                            r_cyc <= r_cyc + 32'd7;
                            r_p[ebc_pkg::FLAG_I] <= 1'b1;
                            r_addr <= ebc_pkg::VEC_BRK; r_dst <= D_VLO;
                            r_state <= S_WAIT;
                        end
                        ebc_pkg::OP_INX: begin
                            r_cyc <= r_cyc + 32'd2;
                            r_x <= r_x + 8'd1; r_p <= zn(r_p, r_x + 8'd1);
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_cyc <= r_cyc + 32'd2;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_OPER1: begin
                    // address of the operand byte is in flight
                    if (r_opc == ebc_pkg::OP_JMP || r_opc == ebc_pkg::OP_LDA_A
                        || r_opc == ebc_pkg::OP_STA) begin
                        r_dst <= D_LO; r_state <= S_MEMRD;
                    end else begin
                        r_pc <= r_pc + 16'd1;
                        r_state <= S_OPER2;
                    end
                end
                S_OPER2: begin
                    // apply the immediate byte
                    r_state <= S_DONE;
                    unique case (r_opc)
                        ebc_pkg::OP_LDA_I: begin
                            r_a <= w_rdata; r_p <= zn(r_p, w_rdata);
                        end
                        ebc_pkg::OP_LDX: begin
                            r_x <= w_rdata; r_p <= zn(r_p, w_rdata);
                        end
                        ebc_pkg::OP_LDY: begin
                            r_y <= w_rdata; r_p <= zn(r_p, w_rdata);
                        end
                        ebc_pkg::OP_ADC: begin
                            r_a <= w_res;
                            r_p <= zn({r_p[7], ~(r_a[7] ^ w_rdata[7]) & (r_a[7] ^ w_res[7]),
                                r_p[5:1], w_sum[8]}, w_res);
                        end
                        default: begin
                            if (!r_p[ebc_pkg::FLAG_Z]) begin
                                r_pc <= w_bto;
                                r_cyc <= r_cyc + ((w_bto[15:8] != r_pc[15:8])
                                    ? 32'd2 : 32'd1);
                            end
                        end
                    endcase
                end
                S_FETCH: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_valid && !o_res.ready, r_valid)
    `ASSERT_IMPL(a_busy, i_clk, i_rst_n, !(i_cmd.ready && r_state != S_IDLE))
    `ASSERT_NEXT(a_take, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, r_state == S_DISPATCH)
endmodule
`default_nettype wire

// ===== sim/tb_eight_bit_cpu_subset_step.sv =====
// Self-checking bench for the processor subset step block: random and directed
// command items, a behavioral processor predictor, and in-order result checks.
// Depends on ebc_pkg, ebc_if and the eight_bit_cpu_subset_step RTL.
`timescale 1ns / 1ps
module tb_eight_bit_cpu_subset_step;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_cmd_item;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  p;
        logic [7:0]  sp;
        logic [31:0] cyc;
        logic [7:0]  rd;
    } t_cpu_state;

    // Fixed landing addresses behind the BRK and NMI vectors
    localparam logic [15:0] BRK_TARGET = 16'h4000;
    localparam logic [15:0] NMI_TARGET = 16'h5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors = 0;

    ebc_cmd_if cmd_ch ();
    ebc_res_if res_ch ();

    eight_bit_cpu_subset_step #(.ADDR_BITS(16)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: processor registers plus a shadow of the memory
    logic [7:0]  shadow_mem [logic [15:0]];
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_p, cpu_sp;
    logic [15:0] cpu_pc;
    logic [31:0] cpu_cyc;

    t_cmd_item  pending_cmds[$];
    t_cpu_state expected_states[$];
    int         pause_at = -1;
    int         cmds_sent = 0;
    int         steps_seen = 0;

    function automatic logic [7:0] peek(logic [15:0] ad);
        return shadow_mem.exists(ad) ? shadow_mem[ad] : 8'h00;
    endfunction

    function automatic logic [7:0] fetch_byte();
        logic [7:0] v;
        v = peek(cpu_pc);
        cpu_pc = cpu_pc + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [7:0] lo;
        lo = fetch_byte();
        return {fetch_byte(), lo};
    endfunction

    function automatic void set_zn(logic [7:0] v);
        cpu_p[ebc_pkg::FLAG_Z] = (v == 8'h00);
        cpu_p[ebc_pkg::FLAG_N] = v[7];
    endfunction

    function automatic void push_byte(logic [7:0] v);
        shadow_mem[{ebc_pkg::STACK_PAGE, cpu_sp}] = v;
        cpu_sp = cpu_sp - 8'd1;
    endfunction

    function automatic logic [7:0] pull_byte();
        cpu_sp = cpu_sp + 8'd1;
        return peek({ebc_pkg::STACK_PAGE, cpu_sp});
    endfunction

    // Execute one instruction at PC
    function automatic void exec_instr();
        logic [7:0]  opc, op, lo, hi;
        logic [8:0]  sum;
        logic [15:0] tgt, from;
        opc = fetch_byte();
        case (opc)
            ebc_pkg::OP_JMP: begin
                cpu_pc = fetch_word();
                cpu_cyc += 3;
            end
            ebc_pkg::OP_LDA_I: begin
                cpu_a = fetch_byte(); set_zn(cpu_a); cpu_cyc += 2;
            end
            ebc_pkg::OP_LDA_A: begin
                tgt = fetch_word(); cpu_a = peek(tgt); set_zn(cpu_a); cpu_cyc += 4;
            end
            ebc_pkg::OP_LDX: begin
                cpu_x = fetch_byte(); set_zn(cpu_x); cpu_cyc += 2;
            end
            ebc_pkg::OP_LDY: begin
                cpu_y = fetch_byte(); set_zn(cpu_y); cpu_cyc += 2;
            end
            ebc_pkg::OP_STA: begin
                tgt = fetch_word(); shadow_mem[tgt] = cpu_a; cpu_cyc += 4;
            end
            ebc_pkg::OP_ADC: begin
                op = fetch_byte();
                sum = {1'b0, cpu_a} + {1'b0, op} + {8'd0, cpu_p[ebc_pkg::FLAG_C]};
                cpu_p[ebc_pkg::FLAG_C] = sum[8];
                cpu_p[ebc_pkg::FLAG_V] = ~(cpu_a[7] ^ op[7]) & (cpu_a[7] ^ sum[7]);
                cpu_a = sum[7:0];
                set_zn(cpu_a);
                cpu_cyc += 2;
            end
            ebc_pkg::OP_PHA: begin
                push_byte(cpu_a); cpu_cyc += 3;
            end
            ebc_pkg::OP_PLA: begin
                cpu_a = pull_byte(); set_zn(cpu_a); cpu_cyc += 4;
            end
            ebc_pkg::OP_INX: begin
                cpu_x = cpu_x + 8'd1; set_zn(cpu_x); cpu_cyc += 2;
            end
            ebc_pkg::OP_BNE: begin
                op = fetch_byte();
                cpu_cyc += 2;
                if (!cpu_p[ebc_pkg::FLAG_Z]) begin
                    from = cpu_pc;
                    tgt = from + {{8{op[7]}}, op};
                    cpu_cyc += 1;
                    if (from[15:8] != tgt[15:8]) cpu_cyc += 1;
                    cpu_pc = tgt;
                end
            end
            ebc_pkg::OP_BRK: begin
                cpu_p[ebc_pkg::FLAG_I] = 1'b1;
                cpu_pc = {peek(ebc_pkg::VEC_BRK + 16'd1), peek(ebc_pkg::VEC_BRK)};
                cpu_cyc += 7;
            end
            ebc_pkg::OP_RTI: begin
                cpu_p = pull_byte();
                lo = pull_byte();
                hi = pull_byte();
                cpu_pc = {hi, lo};
                cpu_cyc += 6;
            end
            default: cpu_cyc += 2;
        endcase
    endfunction

    function automatic t_cpu_state predict_command(t_cmd_item it);
        t_cpu_state s;
        logic [7:0] rd;
        rd = 8'h00;
        case (it.cmd)
            ebc_pkg::CMD_STEP: exec_instr();
            ebc_pkg::CMD_RESET: begin
                cpu_a = '0; cpu_x = '0; cpu_y = '0; cpu_cyc = '0;
                cpu_sp = ebc_pkg::SP_INIT;
                cpu_p = ebc_pkg::STATUS_INIT;
                cpu_pc = {peek(ebc_pkg::VEC_RESET + 16'd1), peek(ebc_pkg::VEC_RESET)};
            end
            ebc_pkg::CMD_NMI: begin
                push_byte(cpu_pc[15:8]);
                push_byte(cpu_pc[7:0]);
                push_byte((cpu_p & ~(8'h1 << ebc_pkg::FLAG_B)) | (8'h1 << ebc_pkg::FLAG_U));
                cpu_p[ebc_pkg::FLAG_I] = 1'b1;
                cpu_pc = {peek(ebc_pkg::VEC_NMI + 16'd1), peek(ebc_pkg::VEC_NMI)};
                cpu_cyc += 7;
            end
            ebc_pkg::CMD_WRITE: shadow_mem[it.addr] = it.data;
            ebc_pkg::CMD_READ: rd = peek(it.addr);
            default: ;
        endcase
        s = '{cpu_pc, cpu_a, cpu_x, cpu_y, cpu_p, cpu_sp, cpu_cyc, rd};
        return s;
    endfunction

    // Stimulus helpers: every read target is written first
    logic written [logic [15:0]];

    task automatic add_cmd(logic [2:0] c, logic [15:0] ad, logic [7:0] dt);
        pending_cmds.push_back('{c, ad, dt});
        if (c == ebc_pkg::CMD_WRITE) written[ad] = 1'b1;
    endtask

    task automatic poke(logic [15:0] ad, logic [7:0] dt);
        add_cmd(ebc_pkg::CMD_WRITE, ad, dt);
    endtask

    // Program area base for random programs; each program is a fresh block
    logic [15:0] prog_base;

    // Pick a program start well away from the vectors and the stack page
    function automatic logic [15:0] fresh_base();
        return {4'($urandom_range(6, 14)), 12'($urandom_range(0, 4000))};
    endfunction

    // Bytes taken by an instruction; unknown opcodes take one
    function automatic logic [15:0] instr_len(logic [7:0] opc);
        case (opc)
            ebc_pkg::OP_JMP, ebc_pkg::OP_LDA_A, ebc_pkg::OP_STA: return 16'd3;
            ebc_pkg::OP_LDA_I, ebc_pkg::OP_LDX, ebc_pkg::OP_LDY, ebc_pkg::OP_ADC,
            ebc_pkg::OP_BNE: return 16'd2;
            default: return 16'd1;
        endcase
    endfunction

    // Put PC at a new program start through the reset vector
    task automatic do_reset_to(logic [15:0] ad);
        poke(ebc_pkg::VEC_RESET, ad[7:0]);
        poke(ebc_pkg::VEC_RESET + 16'd1, ad[15:8]);
        add_cmd(ebc_pkg::CMD_RESET, 16'($urandom), 8'($urandom));
        prog_base = ad;
    endtask

    // Emit one instruction at prog_base and step it; all bytes it touches are
    // written beforehand, and the stack page is prefilled.
    task automatic emit_instr(logic [7:0] opc);
        logic [15:0] tgt;
        logic [7:0]  b1;
        b1 = 8'($urandom_range(0, 255));
        tgt = {8'($urandom_range(2, 63)), 8'($urandom_range(0, 255))};
        if (!written.exists(tgt)) poke(tgt, 8'($urandom_range(0, 255)));
        poke(prog_base, opc);
        case (opc)
            ebc_pkg::OP_JMP, ebc_pkg::OP_LDA_A, ebc_pkg::OP_STA: begin
                poke(prog_base + 16'd1, tgt[7:0]);
                poke(prog_base + 16'd2, tgt[15:8]);
            end
            ebc_pkg::OP_LDA_I, ebc_pkg::OP_LDX, ebc_pkg::OP_LDY, ebc_pkg::OP_ADC,
            ebc_pkg::OP_BNE:
                poke(prog_base + 16'd1, b1);
            default: ;
        endcase
        add_cmd(ebc_pkg::CMD_STEP, 16'($urandom), 8'($urandom));
        // Follow PC: known targets continue there, unknown ones restart
        case (opc)
            ebc_pkg::OP_JMP: prog_base = tgt;
            ebc_pkg::OP_BRK: prog_base = BRK_TARGET;
            ebc_pkg::OP_BNE, ebc_pkg::OP_RTI: do_reset_to(fresh_base());
            default: prog_base = prog_base + instr_len(opc);
        endcase
    endtask

    localparam logic [7:0] OPS [15] = '{ebc_pkg::OP_NOP, ebc_pkg::OP_JMP,
        ebc_pkg::OP_LDA_I, ebc_pkg::OP_LDA_A, ebc_pkg::OP_LDX, ebc_pkg::OP_LDY,
        ebc_pkg::OP_STA, ebc_pkg::OP_ADC, ebc_pkg::OP_PHA, ebc_pkg::OP_PLA,
        ebc_pkg::OP_INX, ebc_pkg::OP_BNE, ebc_pkg::OP_BRK, ebc_pkg::OP_RTI, 8'hFF};

    // Driver: present queued items with random gaps, pausing once at pause_at until all results are back
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (cmd_ch.valid && !cmd_ch.ready) begin
            // hold item
        end else if (gap_left > 0) begin
            cmd_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0
                     && !(cmds_sent == pause_at && expected_states.size() > 0)) begin
            t_cmd_item it;
            it = pending_cmds.pop_front();
            cmd_ch.valid    <= 1'b1;
            cmd_ch.cmd      <= it.cmd;
            cmd_ch.mem_addr <= it.addr;
            cmd_ch.mem_data <= it.data;
            expected_states.push_back(predict_command(it));
            cmds_sent <= cmds_sent + 1;
            if (it.cmd == ebc_pkg::CMD_STEP) steps_seen <= steps_seen + 1;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        end else begin
            cmd_ch.valid <= 1'b0;
        end
    end

    // Monitor: random backpressure and field checks
    int stall_left = 0;
    int results_seen = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_cpu_state got, want;
                got = '{res_ch.prog_counter, res_ch.accum, res_ch.index_x, res_ch.index_y,
                        res_ch.flags, res_ch.stack_ptr, res_ch.cycle_total,
                        res_ch.read_data};
                results_seen <= results_seen + 1;
                if (expected_states.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_states.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                res_ch.ready <= 1'b1;
                if (res_ch.valid && res_ch.ready && $urandom_range(0, 2) != 0)
                    stall_left <= $urandom_range(0, 11);
            end
        end
    end

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = ebc_pkg::CMD_STEP;
        cmd_ch.mem_addr = 16'h0;
        cmd_ch.mem_data = 8'h0;
        res_ch.ready = 1'b0;
        cpu_a = '0; cpu_x = '0; cpu_y = '0;
        cpu_p = ebc_pkg::STATUS_INIT; cpu_sp = ebc_pkg::SP_INIT;
        cpu_pc = '0; cpu_cyc = '0;

        // Prefill vectors and stack page so no unwritten byte is ever read
        poke(ebc_pkg::VEC_BRK, BRK_TARGET[7:0]);
        poke(ebc_pkg::VEC_BRK + 16'd1, BRK_TARGET[15:8]);
        poke(ebc_pkg::VEC_NMI, NMI_TARGET[7:0]);
        poke(ebc_pkg::VEC_NMI + 16'd1, NMI_TARGET[15:8]);
        for (int i = 0; i < 256; i++) poke({ebc_pkg::STACK_PAGE, 8'(i)}, 8'(i ^ 8'h5A));

        // Directed: field extremes, every opcode, BNE page cross, wraps
        poke(16'hFFFF, 8'hFF); poke(16'h0000, 8'h00);
        add_cmd(ebc_pkg::CMD_READ, 16'hFFFF, 8'h00);
        add_cmd(ebc_pkg::CMD_READ, 16'h0000, 8'hFF);
        add_cmd(3'd7, 16'hFFFF, 8'hFF);
        add_cmd(3'd5, 16'h0000, 8'h00);
        do_reset_to(16'h20F8);
        emit_instr(ebc_pkg::OP_LDA_I); emit_instr(ebc_pkg::OP_ADC);
        emit_instr(ebc_pkg::OP_ADC);
        emit_instr(ebc_pkg::OP_BNE); // may cross a page
        do_reset_to(16'h3000);
        foreach (OPS[i]) emit_instr(OPS[i]);
        add_cmd(ebc_pkg::CMD_NMI, 16'h0, 8'h0);
        add_cmd(ebc_pkg::CMD_NMI, 16'h0, 8'h0);

        // Random: mostly fresh programs run from reset, with some noise
        while (pending_cmds.size() < 820) begin
            int len;
            if (pending_cmds.size() > 550 && pause_at < 0) pause_at = pending_cmds.size();
            do_reset_to(fresh_base());
            len = $urandom_range(3, 12);
            for (int k = 0; k < len; k++) begin
                emit_instr(($urandom_range(0, 9) == 0) ? 8'($urandom) :
                           OPS[$urandom_range(0, 14)]);
                if ($urandom_range(0, 15) == 0) begin
                    add_cmd(ebc_pkg::CMD_NMI, 16'($urandom), 8'($urandom));
                    prog_base = NMI_TARGET;
                end
                if ($urandom_range(0, 7) == 0) begin
                    logic [15:0] ad;
                    ad = 16'($urandom);
                    if (written.exists(ad)) add_cmd(ebc_pkg::CMD_READ, ad, 8'($urandom));
                    else if (ad < 16'hFF00) poke(ad, 8'($urandom));
                end
                if ($urandom_range(0, 40) == 0) add_cmd(3'($urandom_range(5, 7)),
                                                        16'($urandom), 8'($urandom));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_cmds.size() == 0 && expected_states.size() == 0);
        repeat (30) @(posedge i_clk);
        $display("tb: %0d command items sent, %0d instruction steps, %0d results checked",
                 cmds_sent, steps_seen, results_seen);
        if (errors == 0 && expected_states.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ebc_pkg.sv
hdl/ebc_if.sv
hdl/ebc_ram.sv
hdl/eight_bit_cpu_subset_step.sv
sim/tb_eight_bit_cpu_subset_step.sv
